// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, muted during reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, muted during reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: rtl/core/fhc_pkg.sv
`timescale 1ns / 1ps
package fhc_pkg;
   localparam int unsigned WordWidth = 32;

   typedef enum logic {
      OP_TO_HALF  = 1'b0,
      OP_TO_FLOAT = 1'b1
   } op_type;

   localparam logic [31:0] F32Inf    = 32'h7f80_0000;
   localparam logic [31:0] F32RMask  = 32'hffff_f000;
   localparam logic [31:0] F16InfX   = 32'h0f80_0000;
   localparam logic [31:0] Rebias    = 32'h3800_0000;
   localparam logic [15:0] HalfQnan  = 16'h7e00;
   localparam logic [15:0] HalfInf   = 16'h7c00;
   localparam logic [31:0] RoundBit  = 32'h0000_1000;
   localparam logic [7:0]  MinNormE  = 8'd113;

   // Work carried between stages
   typedef struct packed {
      op_type      op;
      logic [31:0] word;    // stage-dependent payload
      logic        sgn;
      logic        special; // result already final
      logic [31:0] fixed;   // final value when special
      logic [4:0]  shamt;   // right shift (to half) / left norm (to float)
      logic        sub;     // denormal path
   } stage_type;
endpackage

// File: rtl/core/fhc_stage.sv
`timescale 1ns / 1ps
// One pipeline register slot with valid and stall handling
module fhc_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  fhc_pkg::stage_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output fhc_pkg::stage_type  out_data
);
   import fhc_pkg::*;
   logic      valid_ff;
   stage_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end
endmodule

// File: rtl/core/float_half_convert_unit.sv
`timescale 1ns / 1ps
// binary32 <-> binary16 converter, streaming.
// Input channel req_: tdata = {operand[31:0]}, tuser = op
//   (0: binary32 -> binary16, 1: binary16 -> binary32 from operand[15:0]).
// Output channel rsp_: tdata = result[31:0]; a half result sits in bits
//   15..0 with the upper half zero.
// Each item passes the stage 1, 2 and 3 registers in turn; rsp_tvalid
//   rises once it sits in stage 3, and it is taken while rsp_tready is high.
// Throughput: one item per cycle while rsp_tready stays high; each of the three
//   register stages holds one item, and stall propagates back through per-stage ready.
// Stage 1 decodes specials and computes shift amounts, stage 2 does the
//   denormal shift/round or normalization, stage 3 rebiases, rounds with
//   bit 12, saturates and packs the result.
// Reset (synchronous, active high) empties all stages; nothing is lost
//   or repeated while rsp_tready is low, items simply wait in place and
//   req_tready falls once every stage is full.
module float_half_convert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result
);
   import fhc_pkg::*;
   `include "assert_macros.svh"

   stage_type s1_in, s1_q, s2_in, s2_q, s3_in, s3_q;
   logic v1, v2, r1, r2, r3;

   // ---- stage 1: classify ----
   logic [31:0] mag, mr;
   logic [7:0]  e;
   logic [15:0] h;
   logic [9:0]  hm;
   logic [4:0]  lz;
   always_comb begin
      s1_in         = '0;
      s1_in.op      = op_type'(req_tuser);
      mag           = {1'b0, req_tdata[30:0]};
      mr            = mag & F32RMask;
      e             = mr[30:23];
      h             = req_tdata[15:0];
      hm            = h[9:0];
      lz            = 5'd0;
      for (int i = 0; i < 10; i++) begin
         if (hm[i]) lz = 5'(9 - i);
      end
      if (s1_in.op == OP_TO_HALF) begin
         s1_in.sgn  = req_tdata[31];
         s1_in.word = mr;
         if (mag > F32Inf) begin
            s1_in.special = 1'b1;
            s1_in.fixed   = {16'd0, req_tdata[31], HalfQnan[14:0]};
         end else if (mag == F32Inf) begin
            s1_in.special = 1'b1;
            s1_in.fixed   = {16'd0, req_tdata[31], HalfInf[14:0]};
         end else if (e == 8'd0) begin
            s1_in.special = 1'b1;
            s1_in.fixed   = {16'd0, req_tdata[31], 15'd0};
         end else if (e < MinNormE) begin
            s1_in.sub = 1'b1;
            if (MinNormE - e >= 8'd25) begin
               s1_in.special = 1'b1;
               s1_in.fixed   = {16'd0, req_tdata[31], 15'd0};
            end else begin
               s1_in.shamt = 5'(MinNormE - e);
            end
         end
      end else begin
         s1_in.sgn  = h[15];
         s1_in.word = {16'd0, h};
         if (h[14:10] == 5'd0) begin
            if (hm == 10'd0) begin
               s1_in.special = 1'b1;
               s1_in.fixed   = {h[15], 31'd0};
            end else begin
               s1_in.sub   = 1'b1;
               s1_in.shamt = lz + 5'd1;
            end
         end
      end
   end

   fhc_stage u_s1 (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(s1_in), .out_valid(v1), .out_ready(r2), .out_data(s1_q));

   // ---- stage 2: shift / round-to-even or normalize ----
   logic [23:0] sig, q, rem, half, msk;
   logic [10:0] nm;
   always_comb begin
      s2_in = s1_q;
      sig   = {1'b1, s1_q.word[22:0]};
      q     = sig >> s1_q.shamt;
      msk   = (24'd1 << s1_q.shamt) - 24'd1;
      rem   = sig & msk;
      half  = 24'd1 << (s1_q.shamt - 5'd1);
      nm    = {1'b0, s1_q.word[9:0]} << s1_q.shamt;
      if (!s1_q.special && s1_q.sub) begin
         if (s1_q.op == OP_TO_HALF) begin
            if (rem > half || (rem == half && q[0])) q = q + 24'd1;
            s2_in.word = {8'd0, q};
         end else begin
            s2_in.word = {16'd0, 6'd0, nm[9:0]};
         end
      end
   end

   fhc_stage u_s2 (.clock, .reset, .in_valid(v1), .in_ready(r2),
      .in_data(s2_in), .out_valid(v2), .out_ready(r3), .out_data(s2_q));

   // ---- stage 3: rebias, round, saturate, pack ----
   logic [31:0] b;
   logic [7:0]  fe;
   always_comb begin
      s3_in = s2_q;
      b     = 32'd0;
      fe    = 8'd0;
      if (s2_q.special) begin
         s3_in.word = s2_q.fixed;
      end else if (s2_q.op == OP_TO_HALF) begin
         b = (s2_q.sub ? s2_q.word : s2_q.word - Rebias) + RoundBit;
         if (b > F16InfX) b = F16InfX;
         s3_in.word = {16'd0, s2_q.sgn, b[27:13]};
      end else if (s2_q.sub) begin
         fe = MinNormE - {3'd0, s2_q.shamt};
         s3_in.word = {s2_q.sgn, fe, s2_q.word[9:0], 13'd0};
      end else if (s2_q.word[14:10] == 5'h1f) begin
         s3_in.word = {s2_q.sgn, 8'hff, s2_q.word[9:0], 13'd0};
      end else begin
         fe = {3'd0, s2_q.word[14:10]} + 8'd112;
         s3_in.word = {s2_q.sgn, fe, s2_q.word[9:0], 13'd0};
      end
   end

   fhc_stage u_s3 (.clock, .reset, .in_valid(v2), .in_ready(r3),
      .in_data(s3_in), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_data(s3_q));

   assign r1        = req_tready;
   assign rsp_tdata = s3_q.word;

   // half results never set the upper half
   `ASSERT_IMPL(a_half_upper, clock, reset,
      rsp_tvalid && s3_q.op == OP_TO_HALF, rsp_tdata[31:16] == 16'd0)
   // a stalled result holds its payload
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   // input backpressure only when the front stage is full
   `ASSERT_IMPL(a_ready, clock, reset, !r1, v1)
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import fhc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] operand
   logic        req_tuser = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result

   localparam int WatchdogLimit = 2000;

   float_half_convert_unit DUT (.*);

   always #5 clock = ~clock;

   logic [31:0] expected_words[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   bit          idle_enable = 1'b1;
   bit          hold_off = 1'b0;
   int          stall_cycles = 0;
   int          quiet_cycles = 0;

   // binary32 -> binary16 with mask, rebias, denormal round-to-even, round-half-up at bit 12
   function automatic logic [31:0] float_to_half(logic [31:0] x);
      logic [31:0] sgn, mag, b, sig, q, rem, half;
      logic [7:0]  e;
      int          s;
      sgn = {16'h0, x[31], 15'h0};
      mag = {1'b0, x[30:0]};
      if (mag > F32Inf) return sgn | {16'h0, HalfQnan};
      if (mag == F32Inf) return sgn | {16'h0, HalfInf};
      mag = mag & F32RMask;
      e = mag[30:23];
      if (e >= MinNormE) begin
         b = mag - Rebias;
      end else if (e == 0) begin
         b = '0;
      end else begin
         sig = {8'h0, 1'b1, mag[22:0]};
         s = 113 - e;
         if (s >= 25) begin
            b = '0;
         end else begin
            q = sig >> s;
            rem = sig & ((32'd1 << s) - 1);
            half = 32'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
            b = q;
         end
      end
      b = b + RoundBit;
      if (b > F16InfX) b = F16InfX;
      return sgn | (b >> 13);
   endfunction

   // exact binary16 -> binary32
   function automatic logic [31:0] half_to_float(logic [15:0] h);
      logic [4:0]  ex;
      logic [10:0] m;
      logic [7:0]  e;
      ex = h[14:10];
      m = {1'b0, h[9:0]};
      if (ex == 5'h1f) return {h[15], 8'hff, m[9:0], 13'h0};
      if (ex != 0) return {h[15], 8'(ex) + 8'd112, m[9:0], 13'h0};
      if (m == 0) return {h[15], 31'h0};
      e = 8'd113;
      while (!m[10]) begin
         m = m << 1;
         e = e - 1;
      end
      return {h[15], e, m[9:0], 13'h0};
   endfunction

   function automatic logic [31:0] converted_word(op_type op, logic [31:0] v);
      return (op == OP_TO_HALF) ? float_to_half(v) : half_to_float(v[15:0]);
   endfunction

   task automatic send_item(op_type op, logic [31:0] v);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= v;
      expected_words.push_back(converted_word(op, v));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic release_channel();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      release_channel();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 6) == 0) begin
         stall_cycles <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            want = expected_words.pop_front();
            if (want !== rsp_tdata) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %h actual %h", want, rsp_tdata);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_half_special_cases();
      // zero, denormal, tiny, rounding edges, max, overflow, inf, NaN
      send_item(OP_TO_HALF, 32'h0000_0000);
      send_item(OP_TO_HALF, 32'h8000_0000);
      send_item(OP_TO_HALF, 32'h0000_0001);
      send_item(OP_TO_HALF, 32'h3380_0000);
      send_item(OP_TO_HALF, 32'h3300_0000);
      send_item(OP_TO_HALF, 32'h3880_0000);
      send_item(OP_TO_HALF, 32'h3f80_0fff);
      send_item(OP_TO_HALF, 32'h3f80_1000);
      send_item(OP_TO_HALF, 32'h477f_e000);
      send_item(OP_TO_HALF, 32'h477f_f000);
      send_item(OP_TO_HALF, 32'hff7f_ffff);
      send_item(OP_TO_HALF, 32'h7f80_0000);
      send_item(OP_TO_HALF, 32'hff80_0000);
      send_item(OP_TO_HALF, 32'h7f80_0001);
      send_item(OP_TO_HALF, 32'hffff_ffff);
   endtask

   task automatic test_float_special_cases();
      // upper half ignored, denormals, signed zero, inf, NaN payload
      send_item(OP_TO_FLOAT, 32'hffff_0000);
      send_item(OP_TO_FLOAT, 32'h0000_8000);
      send_item(OP_TO_FLOAT, 32'h1234_0001);
      send_item(OP_TO_FLOAT, 32'h0000_83ff);
      send_item(OP_TO_FLOAT, 32'h0000_0400);
      send_item(OP_TO_FLOAT, 32'h0000_7bff);
      send_item(OP_TO_FLOAT, 32'h0000_fc00);
      send_item(OP_TO_FLOAT, 32'h0000_7e01);
      send_item(OP_TO_FLOAT, 32'hffff_fdff);
      wait_drained();
   endtask

   function automatic logic [31:0] random_operand(op_type op);
      logic [31:0] v;
      v = $urandom;
      // mostly values near the half range so rounding paths get hit
      if (op == OP_TO_HALF && $urandom_range(0, 3) != 0)
         v[30:23] = 8'($urandom_range(96, 145));
      return v;
   endfunction

   task automatic test_random_mix(int count);
      op_type op;
      repeat (count) begin
         op = op_type'($urandom_range(0, 1));
         send_item(op, random_operand(op));
      end
   endtask

   task automatic test_backpressure();
      // receiver holds off long enough to fill the pipe and stall input
      int i;
      hold_off = 1'b1;
      fork
         begin
            repeat (40) @(posedge clock);
            hold_off = 1'b0;
         end
         for (i = 0; i < 12; i++) send_item(OP_TO_HALF, random_operand(OP_TO_HALF));
      join
      // sender pauses until every result has come
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_half_special_cases();
      test_float_special_cases();
      test_random_mix(900);
      test_backpressure();
      test_random_mix(700);
      idle_enable = 1'b0;
      test_random_mix(260);
      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d items in both directions, %0d results checked",
               item_count, result_count);
      $display("specials, rounding edges, stalls and back-pressure exercised");
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: float_half_convert_unit.f
+incdir+rtl/core
rtl/core/fhc_pkg.sv
rtl/core/fhc_stage.sv
rtl/core/float_half_convert_unit.sv
sim/testbench.sv
